[hdl/hpo_pkg.sv]
`default_nettype none

package hpo_pkg;

    // Table and sample precision
    localparam int SineTableBits = 10;
    localparam int SampleBits    = 16;
    localparam int TblSize       = 1 << SineTableBits;
    localparam int SFrac         = SampleBits - 1;
    localparam int Amp           = (1 << SFrac) - 1;

    // Fixed-point constants
    localparam logic [63:0] Q30One    = 64'd1 << 30;
    localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
    localparam int CoefH2   = 9830;   // 0.3 in Q15
    localparam int CoefH4   = 3277;   // 0.1 in Q15
    localparam int CoefNorm = 10813;  // 0.33 in Q15

    // Datapath widths
    localparam int AccW    = SampleBits + 16;
    localparam int ProdW   = AccW + 14;
    localparam int WaveW   = ProdW - SFrac;
    localparam int ModxW   = 32;
    localparam int MixW    = ((WaveW > ModxW + 3) ? WaveW : ModxW + 3) + 1;
    localparam int ScaledW = MixW + 16;
    localparam int ResW    = ScaledW - 30;

    // Request queue between front and back
    localparam int QueuePtrW = 2;
    localparam int QueueDepth = 1 << QueuePtrW;

    // Configuration port
    localparam int AddrW = 4;

    typedef enum logic [1:0] {
        REG_ENABLE     = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_VOLUME     = 2'd2,
        REG_MOD_AMOUNT = 2'd3
    } t_reg_idx;

    localparam logic        ResetEnable    = 1'b0;
    localparam logic [31:0] ResetPhaseStep = 32'd97392;
    localparam logic [14:0] ResetVolume    = 15'd3277;
    localparam logic [15:0] ResetModAmount = 16'd0;

    typedef struct packed {
        logic               enable;
        logic [31:0]        phase_step;
        logic [14:0]        volume;
        logic signed [15:0] mod_amount;
    } t_cfg;

    // One classified request, as handed from front to back
    typedef struct packed {
        logic               en;
        logic [31:0]        angle;
        logic signed [15:0] x;
    } t_job;

    typedef logic [TblSize-1:0][SFrac-1:0] t_sine_rom;

    // Quarter-wave table, sampled at bin midpoints, Q30 Taylor series to degree 13
    function automatic t_sine_rom build_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] v;
        for (int i = 0; i < TblSize; i++) begin
            x    = (64'(2 * i + 1) * HalfPiQ30) >> (SineTableBits + 1);
            x2   = (x * x) >> 30;
            term = Q30One;
            term = Q30One - ((x2 * term) >> 30) / 156;
            term = Q30One - ((x2 * term) >> 30) / 110;
            term = Q30One - ((x2 * term) >> 30) / 72;
            term = Q30One - ((x2 * term) >> 30) / 42;
            term = Q30One - ((x2 * term) >> 30) / 20;
            term = Q30One - ((x2 * term) >> 30) / 6;
            s    = (x * term) >> 30;
            v    = (s * 64'(Amp) + (Q30One >> 1)) >> 30;
            rom[i] = v[SFrac-1:0];
        end
        return rom;
    endfunction

endpackage

`default_nettype wire

[hdl/hpo_ctrl_if.sv]
`default_nettype none

interface hpo_ctrl_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] control_value;

    modport source (output valid, output control_value, input ready);
    modport sink   (input valid, input control_value, output ready);
endinterface

`default_nettype wire

[hdl/hpo_sample_if.sv]
`default_nettype none

interface hpo_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

[hdl/hpo_regs.sv]
`default_nettype none

module hpo_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hpo_pkg::AddrW-1:0]  paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output hpo_pkg::t_cfg                   o_cfg
);

    hpo_pkg::t_cfg     r_cfg;
    hpo_pkg::t_reg_idx idx;
    logic              wr_en;

    assign idx    = hpo_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= hpo_pkg::ResetEnable;
            r_cfg.phase_step <= hpo_pkg::ResetPhaseStep;
            r_cfg.volume     <= hpo_pkg::ResetVolume;
            r_cfg.mod_amount <= hpo_pkg::ResetModAmount;
        end else if (wr_en) begin
            case (idx)
                hpo_pkg::REG_ENABLE:     r_cfg.enable     <= pwdata[0];
                hpo_pkg::REG_PHASE_STEP: r_cfg.phase_step <= pwdata;
                hpo_pkg::REG_VOLUME:     r_cfg.volume     <= pwdata[14:0];
                hpo_pkg::REG_MOD_AMOUNT: r_cfg.mod_amount <= $signed(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            hpo_pkg::REG_ENABLE:     prdata = {31'd0, r_cfg.enable};
            hpo_pkg::REG_PHASE_STEP: prdata = r_cfg.phase_step;
            hpo_pkg::REG_VOLUME:     prdata = {17'd0, r_cfg.volume};
            hpo_pkg::REG_MOD_AMOUNT: prdata = {16'd0, r_cfg.mod_amount};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/hpo_front.sv]
`default_nettype none

module hpo_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hpo_pkg::t_cfg      i_cfg,
    input  wire logic               i_valid,
    input  wire logic signed [15:0] i_x,
    output logic                    o_ready,
    output logic                    o_push,
    output hpo_pkg::t_job           o_job,
    input  wire logic               i_push_ready
);

    logic [31:0] r_phase;
    logic [31:0] n_phase;
    logic        accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && i_push_ready;
    assign o_push  = accept;

    // Advance first, then offset by x turns (x * 2^17 in 2^-32 turn units)
    assign n_phase     = r_phase + i_cfg.phase_step;
    assign o_job.en    = i_cfg.enable;
    assign o_job.angle = n_phase + {i_x[14:0], 17'd0};
    assign o_job.x     = i_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 32'd0;
        end else if (accept && i_cfg.enable) begin
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

[hdl/hpo_queue.sv]
`default_nettype none

module hpo_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hpo_pkg::t_job i_job,
    output logic               o_push_ready,
    input  wire logic          i_pop,
    output logic               o_valid,
    output hpo_pkg::t_job      o_job
);

    hpo_pkg::t_job                  r_mem [hpo_pkg::QueueDepth];
    logic [hpo_pkg::QueuePtrW-1:0]  r_wr_ptr;
    logic [hpo_pkg::QueuePtrW-1:0]  r_rd_ptr;
    logic [hpo_pkg::QueuePtrW:0]    r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_push_ready = (r_count != (hpo_pkg::QueuePtrW + 1)'(hpo_pkg::QueueDepth));
    assign o_valid      = (r_count != '0);
    assign o_job        = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/hpo_back.sv]
`default_nettype none

module hpo_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hpo_pkg::t_cfg      i_cfg,
    input  wire logic               i_job_valid,
    input  wire hpo_pkg::t_job      i_job,
    output logic                    o_pop,
    output logic                    o_valid,
    output logic signed [15:0]      o_sample,
    input  wire logic               i_ready
);

    localparam int SB = hpo_pkg::SampleBits;
    localparam int TB = hpo_pkg::SineTableBits;

    localparam hpo_pkg::t_sine_rom SineRom = hpo_pkg::build_sine_rom();

    localparam logic signed [14:0] CoefH2   = 15'(hpo_pkg::CoefH2);
    localparam logic signed [14:0] CoefH4   = 15'(hpo_pkg::CoefH4);
    localparam logic signed [14:0] CoefNorm = 15'(hpo_pkg::CoefNorm);

    localparam logic signed [hpo_pkg::ProdW-1:0] NormHalf =
        hpo_pkg::ProdW'(1) << (hpo_pkg::SFrac - 1);
    localparam logic signed [hpo_pkg::ScaledW-1:0] OutHalf =
        hpo_pkg::ScaledW'(1) << 29;
    localparam logic signed [hpo_pkg::ResW-1:0] SatHi = hpo_pkg::ResW'(32767);
    localparam logic signed [hpo_pkg::ResW-1:0] SatLo = -hpo_pkg::ResW'(32768);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD4,
        S_SUM,
        S_NORM,
        S_MIX,
        S_SCALE,
        S_DONE
    } t_state;

    t_state                              r_state;
    logic [31:0]                         r_angle;
    logic signed [15:0]                  r_x;
    logic                                r_zero;
    logic signed [hpo_pkg::AccW-1:0]     r_acc;
    logic signed [hpo_pkg::ProdW-1:0]    r_prod;
    logic signed [hpo_pkg::ModxW-1:0]    r_modx;
    logic signed [hpo_pkg::MixW-1:0]     r_mix;
    logic signed [hpo_pkg::ScaledW-1:0]  r_scaled;
    logic                                r_out_valid;
    logic signed [15:0]                  r_out_sample;
    logic [hpo_pkg::SFrac-1:0]           r_rom_q;
    logic                                r_rom_neg;

    logic [31:0]                         rd_angle;
    logic [TB-1:0]                       rd_idx;
    logic signed [SB-1:0]                rom_val;
    logic signed [14:0]                  coef;
    logic signed [SB+14:0]               harm_term;
    logic signed [hpo_pkg::ProdW-1:0]    prod_next;
    logic signed [hpo_pkg::ModxW-1:0]    modx_next;
    logic signed [hpo_pkg::ProdW-1:0]    wave_full;
    logic signed [hpo_pkg::WaveW-1:0]    wave;
    logic signed [hpo_pkg::MixW-1:0]     mix_next;
    logic signed [hpo_pkg::ScaledW-1:0]  scaled_next;
    logic signed [hpo_pkg::ScaledW-1:0]  out_rnd;
    logic signed [hpo_pkg::ResW-1:0]     res;
    logic signed [15:0]                  res_sat;
    logic                                out_free;
    logic                                take;

    // Fundamental, second and fourth harmonic angles in successive cycles
    always_comb begin
        case (r_state)
            S_RD2:   rd_angle = {r_angle[30:0], 1'b0};
            S_RD4:   rd_angle = {r_angle[29:0], 2'b00};
            default: rd_angle = r_angle;
        endcase
    end

    // Mirror the index in odd quadrants
    assign rd_idx = rd_angle[30] ? ~rd_angle[29 -: TB] : rd_angle[29 -: TB];

    always_ff @(posedge i_clk) begin
        r_rom_q   <= SineRom[rd_idx];
        r_rom_neg <= rd_angle[31];
    end

    assign rom_val   = r_rom_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});
    assign coef      = (r_state == S_RD4) ? CoefH2 : CoefH4;
    assign harm_term = rom_val * coef;

    assign prod_next   = r_acc * CoefNorm;
    assign modx_next   = r_x * i_cfg.mod_amount;
    assign wave_full   = r_prod + NormHalf;
    assign wave        = $signed(wave_full[hpo_pkg::ProdW-1:hpo_pkg::SFrac]);
    assign mix_next    = hpo_pkg::MixW'(wave) + (hpo_pkg::MixW'(r_modx) <<< 3);
    assign scaled_next = r_mix * $signed({1'b0, i_cfg.volume});
    assign out_rnd     = r_scaled + OutHalf;
    assign res         = $signed(out_rnd[hpo_pkg::ScaledW-1:30]);

    always_comb begin
        if (res > SatHi) begin
            res_sat = 16'sh7fff;
        end else if (res < SatLo) begin
            res_sat = -16'sh8000;
        end else begin
            res_sat = res[15:0];
        end
    end

    assign out_free = !r_out_valid || i_ready;
    assign take     = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);
    assign o_pop    = take && i_job_valid;
    assign o_valid  = r_out_valid;
    assign o_sample = r_out_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && !((r_state == S_DONE) && out_free)) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_angle <= i_job.angle;
                r_x     <= i_job.x;
                r_zero  <= !i_job.en;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= i_job.en ? S_RD1 : S_DONE;
                    end
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_acc   <= hpo_pkg::AccW'(rom_val) <<< 15;
                    r_state <= S_RD4;
                end
                S_RD4: begin
                    r_acc   <= r_acc + hpo_pkg::AccW'(harm_term);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_acc   <= r_acc + hpo_pkg::AccW'(harm_term);
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    r_prod  <= prod_next;
                    r_modx  <= modx_next;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_mix   <= mix_next;
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_scaled <= scaled_next;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= r_zero ? 16'sd0 : res_sat;
                        if (i_job_valid) begin
                            r_state <= i_job.en ? S_RD1 : S_DONE;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[hdl/harmonic_phase_oscillator.sv]
`default_nettype none

// Three-harmonic phase oscillator. Each request on i_ctrl is one sample tick carrying a
// signed Q1.15 control value x (one unit is one full turn); each produces exactly one
// signed Q1.15 sample on o_sample, in order. When enabled, the 32-bit phase advances by
// phase_step, the angle t = phase + x is formed, and the block outputs
// sat16(volume * (0.33 * (sin t + 0.3 sin 2t + 0.1 sin 4t) + mod_amount * x)) using a
// quarter-wave table of 2^SineTableBits entries with no interpolation. When disabled it
// outputs zero and holds the phase. The front end accepts a request every cycle while
// its four-deep queue has room. The back-end sequencer reads the three harmonics through
// a single table port, then normalises, mixes and scales through registered multiplier
// steps; a disabled request goes straight to output. It takes the next request only as
// the current sample enters the output register. With an empty queue a request passes
// from the queue through the back-end states into that register, which marks it valid.
// Registers sit on the APB port at byte offsets 0 (enable), 4 (phase_step), 8 (volume,
// Q0.15) and 12 (mod_amount, signed Q4.12); write them only while idle.
module harmonic_phase_oscillator (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [hpo_pkg::AddrW-1:0]  paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    hpo_ctrl_if.sink                        i_ctrl,
    hpo_sample_if.source                    o_sample
);

    hpo_pkg::t_cfg cfg;

    // Front to queue
    logic          push;
    logic          push_ready;
    hpo_pkg::t_job push_job;

    // Queue to back
    logic          job_valid;
    logic          pop;
    hpo_pkg::t_job pop_job;

    // Register bank: holds enable, step, gain and mix amount
    hpo_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Front: accept the request, advance the phase, form the angle and classify
    hpo_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (i_ctrl.valid),
        .i_x          (i_ctrl.control_value),
        .o_ready      (i_ctrl.ready),
        .o_push       (push),
        .o_job        (push_job),
        .i_push_ready (push_ready)
    );

    // Queue: decouple request intake from the sample sequencer
    hpo_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .i_pop        (pop),
        .o_valid      (job_valid),
        .o_job        (pop_job)
    );

    // Back: table lookups, harmonic sum, normalise, mix, gain, saturate and output register
    hpo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid),
        .i_job       (pop_job),
        .o_pop       (pop),
        .o_valid     (o_sample.valid),
        .o_sample    (o_sample.sample),
        .i_ready     (o_sample.ready)
    );

endmodule

`default_nettype wire
